@@ hw/rtl/gcl_pkg.sv @@
// Shared types and constants for the gray convert / line mirror block.
package gcl_pkg;

  localparam int PIX_W = 8;
  localparam int LW_W  = 10;
  localparam int SUM_W = 13;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [LW_W-1:0]  lw_t;
  typedef logic [SUM_W-1:0] sum_t;

  localparam lw_t LINE_WIDTH_RST = 10'd320;
  localparam lw_t LINE_WIDTH_MIN = 10'd2;

  // left half weights
  localparam sum_t WL_R = 13'd11;
  localparam sum_t WL_G = 13'd16;
  localparam sum_t WL_B = 13'd5;
  // right half weights
  localparam sum_t WR_R = 13'd10;
  localparam sum_t WR_G = 13'd12;
  localparam sum_t WR_B = 13'd10;

  localparam int GRAY_SHIFT = 5;

endpackage

@@ hw/rtl/gcl_if.sv @@
// Valid/ready channel interfaces for RGB pixels in and mirrored gray pixels out.
interface gcl_pix_if;
  logic            valid;
  logic            ready;
  gcl_pkg::pix_t   red;
  gcl_pkg::pix_t   green;
  gcl_pkg::pix_t   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface gcl_gray_if;
  logic            valid;
  logic            ready;
  gcl_pkg::pix_t   gray;
  logic            last_in_row;

  modport source (output valid, output gray, output last_in_row, input ready);
  modport sink   (input valid, input gray, input last_in_row, output ready);
endinterface

@@ hw/rtl/gray_convert_line_mirror.sv @@
// Top level: RGB to gray conversion with a ping-pong line store read back mirrored.
//
//  channel   dir  handshake        payload
//  in_pix    in   valid/ready      red, green, blue (8b each)
//  out_gray  out  valid/ready      gray (8b), last_in_row
//  cfg       in   cfg_we           cfg_wdata = line_width (10b)
//
// One pixel per cycle while the output is not stalled; the store is read at accept
// and the result goes into the output register when stage 1 advances.
// The line store is two banks of 2**CW bytes, one read and one write per cycle;
// a read of the entry still being written is forwarded.
// Reset is synchronous; no results come out during the first line after reset.
// A stalled output holds its transaction while one more pixel is taken in.
module gray_convert_line_mirror #(
  parameter int MAX_WIDTH = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  gcl_pix_if.sink            in_pix,
  gcl_gray_if.source         out_gray,
  input  logic               cfg_we,
  input  gcl_pkg::lw_t       cfg_wdata
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int CMPW      = (WW > gcl_pkg::LW_W) ? WW : gcl_pkg::LW_W;
  localparam int HW        = WW + 2;
  localparam int AW        = CW + 1;
  localparam int MEM_DEPTH = 2 ** AW;

  // control and config
  gcl_pkg::lw_t   width_r;
  logic [CW-1:0]  column_r, column_nxt;
  logic           bank_r;
  logic           prev_ready_r;

  // stage 1
  logic           s1_v_r;
  logic           s1_has_out_r;
  logic           s1_last_r;
  logic           s1_right_r;
  logic [AW-1:0]  s1_addr_r;
  gcl_pkg::pix_t  s1_red_r, s1_green_r, s1_blue_r;
  logic           s1_fwd_r;
  gcl_pkg::pix_t  fwd_gray_r;
  gcl_pkg::pix_t  rd_data_r;

  // output register
  logic           out_valid_r;
  gcl_pkg::pix_t  out_gray_r;
  logic           out_last_r;

  gcl_pkg::pix_t  mem [MEM_DEPTH];

  logic             in_acc;
  logic             s1_adv;
  logic [CMPW-1:0]  w_raw;
  logic [CMPW-1:0]  w_clamp;
  logic [WW-1:0]    w_use;
  logic [WW-1:0]    w_m1;
  logic [CW-1:0]    wm1_c;
  logic [CW-1:0]    col_c;
  logic             last_c;
  logic [HW-1:0]    c3;
  logic [HW-1:0]    w3;
  logic             right_c;
  logic [CW-1:0]    rd_col;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             fwd_hit;
  gcl_pkg::sum_t    sum_s1;
  gcl_pkg::pix_t    gray_s1;

  assign s1_adv        = !out_valid_r || out_gray.ready;
  assign in_pix.ready  = !s1_v_r || s1_adv;
  assign in_acc        = in_pix.valid && in_pix.ready;

  // width in use, clamped to [2, MAX_WIDTH]
  always_comb begin
    w_raw = CMPW'(width_r);
    if (w_raw < CMPW'(gcl_pkg::LINE_WIDTH_MIN)) begin
      w_clamp = CMPW'(gcl_pkg::LINE_WIDTH_MIN);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_clamp = CMPW'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    w_use = WW'(w_clamp);
    w_m1  = w_use - WW'(1);
    wm1_c = w_m1[CW-1:0];
  end

  always_comb begin
    if ({1'b0, column_r} >= w_use) begin
      col_c = wm1_c;
    end else begin
      col_c = column_r;
    end
    last_c  = (col_c == wm1_c);
    c3      = (HW'(col_c) << 1) + HW'(col_c);
    w3      = (HW'(w_use) << 1) + HW'(w_use);
    right_c = !(c3 < (w3 >> 1));
    rd_col  = wm1_c - col_c;
    rd_addr = {~bank_r, rd_col};
    wr_addr = {bank_r, col_c};
    // only at a line boundary does the read hit the entry stage 1 is about to write
    fwd_hit = s1_v_r && (s1_addr_r == rd_addr);
    column_nxt = last_c ? '0 : col_c + CW'(1);
  end

  always_comb begin
    if (s1_right_r) begin
      sum_s1 = gcl_pkg::sum_t'(s1_red_r)   * gcl_pkg::WR_R
             + gcl_pkg::sum_t'(s1_green_r) * gcl_pkg::WR_G
             + gcl_pkg::sum_t'(s1_blue_r)  * gcl_pkg::WR_B;
    end else begin
      sum_s1 = gcl_pkg::sum_t'(s1_red_r)   * gcl_pkg::WL_R
             + gcl_pkg::sum_t'(s1_green_r) * gcl_pkg::WL_G
             + gcl_pkg::sum_t'(s1_blue_r)  * gcl_pkg::WL_B;
    end
    gray_s1 = sum_s1[gcl_pkg::SUM_W-1:gcl_pkg::GRAY_SHIFT];
  end

  // line store: read on accept, write when stage 1 retires
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[rd_addr];
    end
    if (s1_v_r && s1_adv) begin
      mem[s1_addr_r] <= gray_s1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= gcl_pkg::LINE_WIDTH_RST;
      column_r     <= '0;
      bank_r       <= 1'b0;
      prev_ready_r <= 1'b0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (in_acc) begin
        column_r <= column_nxt;
        if (last_c) begin
          bank_r       <= ~bank_r;
          prev_ready_r <= 1'b1;
        end
      end
      if (in_pix.ready) begin
        s1_v_r <= in_acc;
      end
      if (s1_adv) begin
        out_valid_r <= s1_v_r && s1_has_out_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_has_out_r <= prev_ready_r;
      s1_last_r    <= last_c;
      s1_right_r   <= right_c;
      s1_addr_r    <= wr_addr;
      s1_red_r     <= in_pix.red;
      s1_green_r   <= in_pix.green;
      s1_blue_r    <= in_pix.blue;
      s1_fwd_r     <= fwd_hit;
      fwd_gray_r   <= gray_s1;
    end
    if (s1_adv && s1_v_r) begin
      out_gray_r <= s1_fwd_r ? fwd_gray_r : rd_data_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_gray.valid       = out_valid_r;
  assign out_gray.gray        = out_gray_r;
  assign out_gray.last_in_row = out_last_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, column_r} < WW'(MAX_WIDTH))
    else $error("column out of range");

  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_c |=> column_r == '0 && bank_r != $past(bank_r) && prev_ready_r)
    else $error("line end did not flip bank");

  a_fwd_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fwd_hit |-> column_r == '0 && s1_last_r)
    else $error("forward outside line boundary");

  a_prev_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(prev_ready_r))
    else $error("previous line flag dropped");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_addr_r) && $stable(rd_data_r))
    else $error("stage 1 lost while stalled");

endmodule
